// ===== rtl/srpg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types and constants for the stepper ramp / PWM rate generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

    localparam int DIV_FRAC_BITS_DEF = 4;
    localparam int CLK_W             = 28;
    localparam int DIVISOR_W         = 32;
    localparam int DIV_INT_MAX       = 255;
    localparam int WRAP_MIN          = 10;
    localparam int WRAP_MAX          = 65535;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_STOP  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        REG_MAX_RATE      = 2'd0,
        REG_RAMP_STEP     = 2'd1,
        REG_RAMP_INTERVAL = 2'd2,
        REG_SYS_CLOCK     = 2'd3
    } reg_index_t;

    // opcode sits in the lowest bits
    typedef struct packed {
        logic        forward;
        logic [15:0] requested_rate;
        logic [31:0] now_ms;
        logic [1:0]  opcode;
    } item_t;

    typedef struct packed {
        logic [15:0] max_rate;
        logic [15:0] ramp_step;
        logic [15:0] ramp_interval_ms;
    } ramp_cfg_t;

    typedef struct packed {
        logic [15:0] rate;
        logic        direction;
        logic        reprog;
    } ramp_status_t;

endpackage : srpg_pkg
`default_nettype wire

// ===== rtl/srpg_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srpg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srpg_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = {1'b0, shifted} - {2'b00, den_reg};
        ge      = ~diff[DIVISOR_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quo_reg shifts the dividend out at the top and the quotient in below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule : srpg_div
`default_nettype wire

// ===== rtl/srpg_ramp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srpg_ramp
// Ramp state: start, tick and stop handling of the step rate.
// ----------------------------------------------------------------------------
module srpg_ramp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire srpg_pkg::item_t      item,
    input  wire srpg_pkg::ramp_cfg_t  cfg,
    output srpg_pkg::ramp_status_t    status
);

    import srpg_pkg::*;

    logic        running_reg;
    logic [15:0] cur_reg;
    logic [15:0] tgt_reg;
    logic [31:0] last_reg;
    logic        dir_reg;
    logic        reprog_reg;

    logic [15:0] req_clamp;
    logic [15:0] step_clamp;
    logic [15:0] start_rate;
    logic [31:0] elapsed;
    logic        due;
    logic [16:0] sum;
    logic [15:0] tick_rate;
    logic        can_tick;

    always_comb
    begin
        req_clamp  = (item.requested_rate < cfg.max_rate) ? item.requested_rate : cfg.max_rate;
        step_clamp = (cfg.ramp_step < cfg.max_rate) ? cfg.ramp_step : cfg.max_rate;
        start_rate = (step_clamp > req_clamp) ? req_clamp : step_clamp;
        // signed reading of the wrapped difference
        elapsed    = item.now_ms - last_reg;
        due        = ~elapsed[31] && (elapsed >= {16'd0, cfg.ramp_interval_ms});
        sum        = {1'b0, cur_reg} + {1'b0, cfg.ramp_step};
        tick_rate  = (sum > {1'b0, tgt_reg}) ? tgt_reg : sum[15:0];
        can_tick   = running_reg && (cur_reg < tgt_reg) && due;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            cur_reg     <= '0;
            tgt_reg     <= '0;
            last_reg    <= '0;
            dir_reg     <= 1'b0;
            reprog_reg  <= 1'b0;
        end
        else if (accept)
        begin
            case (opcode_t'(item.opcode))
                OP_START:
                begin
                    running_reg <= 1'b1;
                    dir_reg     <= item.forward;
                    tgt_reg     <= req_clamp;
                    cur_reg     <= start_rate;
                    last_reg    <= item.now_ms;
                    reprog_reg  <= 1'b1;
                end
                OP_TICK:
                begin
                    reprog_reg <= can_tick;
                    if (can_tick)
                    begin
                        cur_reg  <= tick_rate;
                        last_reg <= item.now_ms;
                    end
                end
                OP_STOP:
                begin
                    running_reg <= 1'b0;
                    cur_reg     <= '0;
                    tgt_reg     <= '0;
                    reprog_reg  <= 1'b1;
                end
                default:
                begin
                    reprog_reg <= 1'b0;
                end
            endcase
        end
    end

    assign status.rate      = cur_reg;
    assign status.direction = dir_reg;
    assign status.reprog    = reprog_reg;

endmodule : srpg_ramp
`default_nettype wire

// ===== rtl/stepper_ramp_pwm_rate_generator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_ramp_pwm_rate_generator_top
// Linear speed ramp for one stepper, turned into PWM divider/wrap/compare.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per item (opcode, ms timestamp, target rate,
//   direction); m_* returns exactly one result per request with the PWM
//   settings for the rate left after that request.
//   cfg_we/cfg_addr/cfg_wdata write max_rate, ramp_step, ramp_interval_ms and
//   system_clock_hz; write only while no request is in flight.
//   One request at a time: s_tready is low from acceptance until the result
//   is loaded into the output register. Both PWM values come out of one
//   shared bit-serial divider, first the clock divider and then the counter
//   wrap, with a multiply between the two. A zero rate skips the divider.
//   If the receiver stalls, the result waits in the output register; the
//   next request is still accepted and its result waits until taken.
//   Reset loads the register defaults, stops the ramp and empties the output.
// ----------------------------------------------------------------------------
module stepper_ramp_pwm_rate_generator_top #(
    parameter int DIV_FRAC_BITS = srpg_pkg::DIV_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [27:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[1:0], now_ms[33:2], requested_rate[49:34], forward[50], zero pad
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pwm_enable[0], clock_divider[12:1], counter_wrap[28:13],
    // compare_level[43:29], present_rate[59:44], direction_out[60],
    // reprogrammed[61], zero pad
    output logic [63:0]      m_tdata
);

    import srpg_pkg::*;

    localparam int DW       = CLK_W + DIV_FRAC_BITS;
    localparam int DIVW     = 8 + DIV_FRAC_BITS;
    localparam int ONE      = 1 << DIV_FRAC_BITS;
    localparam int DIV_MAX  = DIV_INT_MAX * ONE;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV1,
        ST_MUL,
        ST_LAUNCH2,
        ST_DIV2,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [15:0] max_rate_reg;
    logic [15:0] ramp_step_reg;
    logic [15:0] ramp_interval_reg;
    logic [27:0] sys_clock_reg;

    logic [15:0]      eff_reg;
    logic             zero_reg;
    logic [DIVW-1:0]  div_reg;
    logic [31:0]      prod_reg;
    logic             m_tvalid_reg;
    logic [63:0]      m_tdata_reg;

    item_t        item;
    ramp_cfg_t    ramp_cfg;
    ramp_status_t ramp_st;
    logic         accept;

    logic [15:0]          eff_c;
    logic                 div_start;
    logic [DW-1:0]        dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic                 div_done;
    logic [DW-1:0]        quo;

    logic [DIVW-1:0] div_clamped;
    logic [DW-1:0]   quo_m1;
    logic [15:0]     wrap_c;
    logic [31:0]     div_ext;

    assign item     = item_t'(s_tdata[50:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign ramp_cfg.max_rate         = max_rate_reg;
    assign ramp_cfg.ramp_step        = ramp_step_reg;
    assign ramp_cfg.ramp_interval_ms = ramp_interval_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rate_reg      <= 16'd65535;
            ramp_step_reg     <= 16'd100;
            ramp_interval_reg <= 16'd10;
            sys_clock_reg     <= 28'd125000000;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_addr))
                REG_MAX_RATE:      max_rate_reg      <= cfg_wdata[15:0];
                REG_RAMP_STEP:     ramp_step_reg     <= cfg_wdata[15:0];
                REG_RAMP_INTERVAL: ramp_interval_reg <= cfg_wdata[15:0];
                REG_SYS_CLOCK:     sys_clock_reg     <= cfg_wdata;
                default:           max_rate_reg      <= max_rate_reg;
            endcase
        end
    end

    srpg_ramp u_ramp (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (ramp_cfg),
        .status (ramp_st)
    );

    srpg_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        eff_c     = (ramp_st.rate < max_rate_reg) ? ramp_st.rate : max_rate_reg;
        div_start = ((state_reg == ST_PREP) && (eff_c != 16'd0)) || (state_reg == ST_LAUNCH2);
        dividend  = DW'(sys_clock_reg) << DIV_FRAC_BITS;
        // rate * 65535 as a shift and subtract
        if (state_reg == ST_LAUNCH2)
            divisor = prod_reg;
        else
            divisor = {eff_c, 16'd0} - {16'd0, eff_c};

        if (quo < DW'(ONE))
            div_clamped = DIVW'(ONE);
        else if (quo > DW'(DIV_MAX))
            div_clamped = DIVW'(DIV_MAX);
        else
            div_clamped = quo[DIVW-1:0];

        quo_m1 = quo - DW'(1);
        if (quo < DW'(WRAP_MIN + 1))
            wrap_c = 16'(WRAP_MIN);
        else if (quo_m1 > DW'(WRAP_MAX))
            wrap_c = 16'(WRAP_MAX);
        else
            wrap_c = quo_m1[15:0];

        div_ext = 32'(div_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // in ST_DONE the output register is handled by that state alone
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    eff_reg  <= eff_c;
                    zero_reg <= (eff_c == 16'd0);
                    state_reg <= (eff_c == 16'd0) ? ST_DONE : ST_DIV1;
                end
                ST_DIV1:
                begin
                    if (div_done)
                    begin
                        div_reg   <= div_clamped;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= 32'(div_reg) * 32'(eff_reg);
                    state_reg <= ST_LAUNCH2;
                end
                ST_LAUNCH2:
                begin
                    state_reg <= ST_DIV2;
                end
                ST_DIV2:
                begin
                    if (div_done)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        if (zero_reg)
                            m_tdata_reg <= {2'b00, ramp_st.reprog, ramp_st.direction,
                                            ramp_st.rate, 15'd0, 16'd0, 12'd0, 1'b0};
                        else
                            m_tdata_reg <= {2'b00, ramp_st.reprog, ramp_st.direction,
                                            ramp_st.rate, wrap_c[15:1], wrap_c,
                                            div_ext[11:0], 1'b1};
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_compare_half_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |->
            (m_tdata[43:29] == m_tdata[28:14]) && (m_tdata[28:13] >= 16'd10))
        else $error("compare level or wrap out of line with each other");

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[43:1] == 43'd0))
        else $error("PWM settings non-zero while output disabled");
`endif

endmodule : stepper_ramp_pwm_rate_generator_top
`default_nettype wire

// ===== bench/tb_stepper_ramp_pwm_rate_generator_top.sv =====
// ----------------------------------------------------------------------------
// tb_stepper_ramp_pwm_rate_generator_top
// Self-checking bench for the stepper ramp / PWM rate generator. A short
// table of directed requests, some with their results typed in, is followed
// by random start/tick/stop sequences over several register settings. A
// local ramp model predicts every result. Both stream sides idle at random;
// one long receiver hold-off and one sender pause are included.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_pwm_rate_generator_top;
    import srpg_pkg::*;

    localparam int              FRAC_BITS       = DIV_FRAC_BITS_DEF;
    localparam longint unsigned DIV_ONE         = 64'd1 << FRAC_BITS;
    localparam longint unsigned DIV_CEIL        = DIV_INT_MAX * DIV_ONE;
    localparam longint unsigned WRAP_FULL       = 65535;
    localparam logic [1:0]      OP_UNUSED       = 2'd3;
    localparam int              RESULT_LATENCY  = 2 * (CLK_W + FRAC_BITS) + 6;
    localparam int              HOLD_OFF_CYCLES = 2000;
    localparam int              WATCHDOG_LIMIT  = 20000;
    localparam int              PHASES          = 9;
    localparam int              PHASE_REQUESTS  = 45;

    // pad, reprogrammed, direction_out, present_rate, compare_level,
    // counter_wrap, clock_divider, pwm_enable (from the top bit down)
    typedef struct packed {
        logic [1:0]  pad;
        logic        reprogrammed;
        logic        direction_out;
        logic [15:0] present_rate;
        logic [14:0] compare_level;
        logic [15:0] counter_wrap;
        logic [11:0] clock_divider;
        logic        pwm_enable;
    } pwm_result_t;

    typedef struct {
        bit          pinned;
        pwm_result_t want;
    } pin_entry_t;

    typedef struct {
        bit          is_write;
        reg_index_t  reg_idx;
        logic [27:0] value;
        item_t       req;
        bit          pinned;
        pwm_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    reg_index_t  cfg_addr;
    logic [27:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    // opcode[1:0], now_ms[33:2], requested_rate[49:34], forward[50], zero pad
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // pwm_enable[0], clock_divider[12:1], counter_wrap[28:13],
    // compare_level[43:29], present_rate[59:44], direction_out[60],
    // reprogrammed[61], zero pad
    logic [63:0] m_tdata;

    // ramp model state and its copy of the registers
    logic        ramp_running;
    logic [15:0] rate_now;
    logic [15:0] rate_target;
    logic [31:0] last_step_ms;
    logic        dir_latched;
    logic [15:0] cfg_max_rate;
    logic [15:0] cfg_ramp_step;
    logic [15:0] cfg_interval;
    logic [27:0] cfg_sys_clk;

    pwm_result_t pwm_expected[$];
    pin_entry_t  pinned_results[$];
    int          errors;
    int          quiet_cycles;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_off_requests;
    int          hold_off_seen;
    int          hold_left;

    stepper_ramp_pwm_rate_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] clamp_to_max(logic [15:0] r);
        return (r < cfg_max_rate) ? r : cfg_max_rate;
    endfunction

    function automatic pwm_result_t pwm_from_rate(logic reprog);
        logic [15:0]     eff_rate;
        longint unsigned clk_fx;
        longint unsigned rate_w;
        longint unsigned dv;
        longint unsigned quot;
        longint unsigned wrap;
        pwm_result_t     res;
        res = '0;
        eff_rate = clamp_to_max(rate_now);
        if (eff_rate != 16'd0)
        begin
            clk_fx = 64'(cfg_sys_clk);
            clk_fx = clk_fx << FRAC_BITS;
            rate_w = 64'(eff_rate);
            dv = clk_fx / (rate_w * WRAP_FULL);
            if (dv < DIV_ONE)
                dv = DIV_ONE;
            if (dv > DIV_CEIL)
                dv = DIV_CEIL;
            quot = clk_fx / (dv * rate_w);
            // wrap never drops below the floor, even for a tiny quotient
            wrap = (quot < WRAP_MIN + 1) ? WRAP_MIN : quot - 1;
            if (wrap > WRAP_MAX)
                wrap = WRAP_MAX;
            res.pwm_enable    = 1'b1;
            res.clock_divider = dv[11:0];
            res.counter_wrap  = wrap[15:0];
            res.compare_level = wrap[15:1];
        end
        res.present_rate  = rate_now;
        res.direction_out = dir_latched;
        res.reprogrammed  = reprog;
        return res;
    endfunction

    function automatic pwm_result_t ramp_advance(item_t it);
        logic        reprog;
        logic [31:0] gap;
        logic [16:0] next_rate;
        reprog = 1'b0;
        case (it.opcode)
            OP_START:
            begin
                ramp_running = 1'b1;
                dir_latched  = it.forward;
                rate_target  = clamp_to_max(it.requested_rate);
                rate_now     = clamp_to_max(cfg_ramp_step);
                if (rate_now > rate_target)
                    rate_now = rate_target;
                last_step_ms = it.now_ms;
                reprog = 1'b1;
            end
            OP_TICK:
            begin
                if (ramp_running && rate_now < rate_target)
                begin
                    // elapsed time is read as signed, so a timestamp behind us never steps
                    gap = it.now_ms - last_step_ms;
                    if (!gap[31] && gap >= cfg_interval)
                    begin
                        next_rate    = rate_now + cfg_ramp_step;
                        last_step_ms = it.now_ms;
                        rate_now     = (next_rate > rate_target) ? rate_target : next_rate[15:0];
                        reprog = 1'b1;
                    end
                end
            end
            OP_STOP:
            begin
                ramp_running = 1'b0;
                rate_now     = 16'd0;
                rate_target  = 16'd0;
                reprog = 1'b1;
            end
            default: ;
        endcase
        return pwm_from_rate(reprog);
    endfunction

    function automatic item_t make_request(logic [1:0] op, logic [31:0] now,
                                           logic [15:0] rate, logic fwd);
        item_t it;
        it.opcode         = op;
        it.now_ms         = now;
        it.requested_rate = rate;
        it.forward        = fwd;
        return it;
    endfunction

    function automatic pwm_result_t pwm_fields(logic en, logic [11:0] dv, logic [15:0] wrap,
                                               logic [14:0] cmp, logic [15:0] rate,
                                               logic dir, logic reprog);
        pwm_result_t res;
        res = '0;
        res.pwm_enable    = en;
        res.clock_divider = dv;
        res.counter_wrap  = wrap;
        res.compare_level = cmp;
        res.present_rate  = rate;
        res.direction_out = dir;
        res.reprogrammed  = reprog;
        return res;
    endfunction

    function automatic stim_row_t request_row(logic [1:0] op, logic [31:0] now,
                                              logic [15:0] rate, logic fwd);
        stim_row_t row;
        row.is_write = 1'b0;
        row.reg_idx  = REG_MAX_RATE;
        row.value    = '0;
        row.req      = make_request(op, now, rate, fwd);
        row.pinned   = 1'b0;
        row.want     = '0;
        return row;
    endfunction

    function automatic stim_row_t checked_row(logic [1:0] op, logic [31:0] now,
                                              logic [15:0] rate, logic fwd,
                                              pwm_result_t want);
        stim_row_t row;
        row = request_row(op, now, rate, fwd);
        row.pinned = 1'b1;
        row.want   = want;
        return row;
    endfunction

    function automatic stim_row_t write_row(reg_index_t idx, logic [27:0] value);
        stim_row_t row;
        row = request_row(OP_UNUSED, '0, '0, 1'b0);
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.value    = value;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch in %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pwm_expected.size() != 0);
    endtask

    // block is idle here, so the model copy can be updated at once
    task automatic write_reg(input reg_index_t idx, input logic [27:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MAX_RATE:      cfg_max_rate  = value[15:0];
            REG_RAMP_STEP:     cfg_ramp_step = value[15:0];
            REG_RAMP_INTERVAL: cfg_interval  = value[15:0];
            REG_SYS_CLOCK:     cfg_sys_clk   = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // valid stays high between back-to-back requests; it drops for a gap or while the bench drains
    task automatic send_request(input item_t it, input bit pinned, input pwm_result_t want);
        int gap;
        pin_entry_t pin;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < 30)
            gap++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pin.pinned = pinned;
        pin.want   = want;
        pinned_results.push_back(pin);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, it};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // receiver: random stalls, plus a long hold-off counted here on request
    always @(posedge clk)
    begin
        if (hold_off_seen != hold_off_requests)
        begin
            hold_off_seen = hold_off_requests;
            hold_left     = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        pwm_result_t got;
        pwm_result_t want;
        pin_entry_t  pin;
        if (rst_n)
        begin
            quiet_cycles++;
            if (s_tvalid && s_tready)
            begin
                quiet_cycles = 0;
                want = ramp_advance(item_t'(s_tdata[$bits(item_t)-1:0]));
                pin  = pinned_results.pop_front();
                pwm_expected.push_back(pin.pinned ? pin.want : want);
            end
            if (m_tvalid && m_tready)
            begin
                quiet_cycles = 0;
                got = m_tdata;
                if (pwm_expected.size() == 0)
                    report_mismatch("result with no request pending", got, 0);
                else
                begin
                    want = pwm_expected.pop_front();
                    if (got.pwm_enable !== want.pwm_enable)
                        report_mismatch("pwm_enable", got.pwm_enable, want.pwm_enable);
                    if (got.clock_divider !== want.clock_divider)
                        report_mismatch("clock_divider", got.clock_divider, want.clock_divider);
                    if (got.counter_wrap !== want.counter_wrap)
                        report_mismatch("counter_wrap", got.counter_wrap, want.counter_wrap);
                    if (got.compare_level !== want.compare_level)
                        report_mismatch("compare_level", got.compare_level, want.compare_level);
                    if (got.present_rate !== want.present_rate)
                        report_mismatch("present_rate", got.present_rate, want.present_rate);
                    if (got.direction_out !== want.direction_out)
                        report_mismatch("direction_out", got.direction_out, want.direction_out);
                    if (got.reprogrammed !== want.reprogrammed)
                        report_mismatch("reprogrammed", got.reprogrammed, want.reprogrammed);
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t   directed[$];
        logic [31:0] wall_ms;
        logic [15:0] target;
        logic [27:0] value;
        logic [1:0]  op;
        int          phase;
        int          phase_items;
        int          ticks;
        bit          hold_done;
        bit          pause_done;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_addr          = REG_MAX_RATE;
        cfg_wdata         = '0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        errors            = 0;
        quiet_cycles      = 0;
        src_idle_pct      = 10;
        snk_idle_pct      = 47;
        hold_off_requests = 0;
        hold_off_seen     = 0;
        hold_left         = 0;
        hold_done         = 1'b0;
        pause_done        = 1'b0;
        ramp_running      = 1'b0;
        rate_now          = '0;
        rate_target       = '0;
        last_step_ms      = '0;
        dir_latched       = 1'b0;
        cfg_max_rate      = 16'd65535;
        cfg_ramp_step     = 16'd100;
        cfg_interval      = 16'd10;
        cfg_sys_clk       = 28'd125000000;

        // idle after reset, unused opcode, stop and zero-rate start
        directed.push_back(checked_row(OP_TICK, 32'd5, 16'd0, 1'b0,
                                       pwm_fields(0, 0, 0, 0, 0, 0, 0)));
        directed.push_back(checked_row(OP_UNUSED, 32'd0, 16'hFFFF, 1'b1,
                                       pwm_fields(0, 0, 0, 0, 0, 0, 0)));
        directed.push_back(checked_row(OP_STOP, 32'hFFFF_FFFF, 16'd0, 1'b0,
                                       pwm_fields(0, 0, 0, 0, 0, 0, 1)));
        directed.push_back(checked_row(OP_START, 32'd0, 16'd0, 1'b1,
                                       pwm_fields(0, 0, 0, 0, 0, 1, 1)));
        directed.push_back(checked_row(OP_START, 32'd100, 16'hFFFF, 1'b0,
                                       pwm_fields(1, 305, 65535, 32767, 100, 0, 1)));
        directed.push_back(request_row(OP_TICK, 32'd109, 16'd0, 1'b1));
        directed.push_back(request_row(OP_TICK, 32'd110, 16'd0, 1'b1));
        // timestamp behind the last step
        directed.push_back(request_row(OP_TICK, 32'hFFFF_FFF0, 16'd0, 1'b0));
        // restart while running, then step across the 32-bit wrap
        directed.push_back(request_row(OP_START, 32'hFFFF_FFFA, 16'd250, 1'b1));
        directed.push_back(request_row(OP_TICK, 32'd4, 16'd0, 1'b0));
        directed.push_back(request_row(OP_TICK, 32'd14, 16'd0, 1'b0));
        directed.push_back(request_row(OP_TICK, 32'd100, 16'd0, 1'b0));
        directed.push_back(checked_row(OP_STOP, 32'd200, 16'd0, 1'b0,
                                       pwm_fields(0, 0, 0, 0, 0, 1, 1)));
        directed.push_back(write_row(REG_MAX_RATE, 28'd150));
        directed.push_back(request_row(OP_START, 32'd0, 16'hFFFF, 1'b1));
        directed.push_back(request_row(OP_TICK, 32'd10, 16'd0, 1'b0));
        // zero max rate disables output at once but keeps the ramp state
        directed.push_back(write_row(REG_MAX_RATE, 28'd0));
        directed.push_back(checked_row(OP_TICK, 32'd20, 16'd0, 1'b0,
                                       pwm_fields(0, 0, 0, 0, 150, 1, 0)));
        directed.push_back(checked_row(OP_START, 32'd30, 16'd1000, 1'b0,
                                       pwm_fields(0, 0, 0, 0, 0, 0, 1)));
        directed.push_back(write_row(REG_MAX_RATE, 28'd65535));
        directed.push_back(write_row(REG_RAMP_STEP, 28'd65535));
        directed.push_back(write_row(REG_RAMP_INTERVAL, 28'd0));
        directed.push_back(write_row(REG_SYS_CLOCK, 28'd1000000));
        directed.push_back(checked_row(OP_START, 32'd7, 16'hFFFF, 1'b1,
                                       pwm_fields(1, 16, 14, 7, 65535, 1, 1)));
        directed.push_back(request_row(OP_TICK, 32'd7, 16'd0, 1'b1));
        directed.push_back(write_row(REG_SYS_CLOCK, 28'hFFF_FFFF));
        directed.push_back(write_row(REG_RAMP_STEP, 28'd1));
        directed.push_back(write_row(REG_RAMP_INTERVAL, 28'd65535));
        directed.push_back(checked_row(OP_START, 32'd0, 16'd2, 1'b0,
                                       pwm_fields(1, 4080, 65535, 32767, 1, 0, 1)));
        directed.push_back(request_row(OP_TICK, 32'd65534, 16'd0, 1'b0));
        directed.push_back(request_row(OP_TICK, 32'd65535, 16'd0, 1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_write)
                write_reg(directed[i].reg_idx, directed[i].value);
            else
                send_request(directed[i].req, directed[i].pinned, directed[i].want);
        end

        wall_ms = $urandom();
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 3)
                0:       begin src_idle_pct = 10; snk_idle_pct = 47; end
                1:       begin src_idle_pct = 47; snk_idle_pct = 10; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase

            case ($urandom_range(3))
                0:       value = 28'd65535;
                1:       value = 28'd1;
                default: value = 28'($urandom_range(1, 65535));
            endcase
            write_reg(REG_MAX_RATE, value);
            case ($urandom_range(4))
                0:       value = 28'd0;
                1:       value = 28'd65535;
                default: value = 28'($urandom_range(1, 2000));
            endcase
            write_reg(REG_RAMP_STEP, value);
            case ($urandom_range(4))
                0:       value = 28'd0;
                1:       value = 28'd65535;
                default: value = 28'($urandom_range(1, 100));
            endcase
            write_reg(REG_RAMP_INTERVAL, value);
            case ($urandom_range(3))
                0:       value = 28'd1000000;
                1:       value = 28'hFFF_FFFF;
                default: value = 28'($urandom_range(1000000, 28'hFFF_FFFF));
            endcase
            write_reg(REG_SYS_CLOCK, value);

            phase_items = 0;
            while (phase_items < PHASE_REQUESTS)
            begin
                // receiver holds off while requests keep coming, so the input stalls
                if (phase == 0 && phase_items >= 10 && !hold_done)
                begin
                    hold_off_requests++;
                    hold_done = 1'b1;
                end
                if (phase == 4 && phase_items >= 25 && !pause_done)
                begin
                    wait_drained();
                    pause_done = 1'b1;
                end

                if ($urandom_range(99) < 85)
                begin
                    if ($urandom_range(3) == 0)
                        wall_ms = $urandom();
                    case ($urandom_range(5))
                        0:       target = 16'd0;
                        1:       target = 16'hFFFF;
                        default: target = 16'($urandom());
                    endcase
                    send_request(make_request(OP_START, wall_ms, target,
                                              1'($urandom_range(1))), 1'b0, '0);
                    phase_items++;
                    ticks = $urandom_range(1, 12);
                    repeat (ticks)
                    begin
                        if ($urandom_range(19) == 0)
                            wall_ms -= $urandom_range(1, 1000);
                        else if ($urandom_range(3) == 0)
                            wall_ms += $urandom_range(0, cfg_interval);
                        else
                            wall_ms += cfg_interval + $urandom_range(0, 20);
                        send_request(make_request(OP_TICK, wall_ms, 16'($urandom()),
                                                  1'($urandom_range(1))), 1'b0, '0);
                        phase_items++;
                    end
                    if ($urandom_range(1))
                    begin
                        wall_ms += $urandom_range(0, 50);
                        send_request(make_request(OP_STOP, wall_ms, 16'($urandom()),
                                                  1'($urandom_range(1))), 1'b0, '0);
                        phase_items++;
                    end
                end
                else
                begin
                    case ($urandom_range(3))
                        0:       op = OP_START;
                        1:       op = OP_TICK;
                        2:       op = OP_STOP;
                        default: op = OP_UNUSED;
                    endcase
                    send_request(make_request(op, $urandom(), 16'($urandom()),
                                              1'($urandom_range(1))), 1'b0, '0);
                    phase_items++;
                end
            end
        end

        wait_drained();
        repeat (2 * RESULT_LATENCY) @(posedge clk);
        if (errors == 0 && pwm_expected.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
